@@ rtl/uart_16550_register_block_defines.svh @@
// ----------------------------------------------------------------------------
// UART 16550 register block assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UART_16550_REGISTER_BLOCK_DEFINES_SVH
`define UART_16550_REGISTER_BLOCK_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define U16RB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define U16RB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/u16rb_pkg.sv @@
// ----------------------------------------------------------------------------
// UART 16550 register block package
// Commands, register offsets, bit positions, codes and FIFO sizing.
// ----------------------------------------------------------------------------
package u16rb_pkg;

	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_READ    = 2'd0,
		CMD_WRITE   = 2'd1,
		CMD_LINE_RX = 2'd2,
		CMD_TX_SLOT = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_DATA = 3'd0,
		REG_IER  = 3'd1,
		REG_IIR  = 3'd2,
		REG_LCR  = 3'd3,
		REG_LSR  = 3'd5
	} reg_t;

	localparam int LCR_DLAB_BIT   = 7;
	localparam int IER_RDA_BIT    = 0;
	localparam int IER_THRE_BIT   = 1;
	localparam int FCR_EN_BIT     = 0;
	localparam int FCR_RX_CLR_BIT = 1;
	localparam int FCR_TX_CLR_BIT = 2;

	localparam logic [7:0] IIR_RDA      = 8'h04;
	localparam logic [7:0] IIR_THRE     = 8'h02;
	localparam logic [7:0] IIR_NONE     = 8'h01;
	localparam logic [7:0] IIR_FIFO_ON  = 8'hC0;
	localparam logic [7:0] LSR_DR       = 8'h01;
	localparam logic [7:0] LSR_TX_IDLE  = 8'h60;

	// Control carried from the accept cycle to the memory read cycle.
	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
		logic       rx_pop;
		logic       tx_pop;
	} s1_t;

endpackage

@@ rtl/u16rb_ifs.sv @@
// ----------------------------------------------------------------------------
// UART 16550 register block channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface u16rb_req_if import u16rb_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [2:0] reg_addr;
	logic [7:0] write_data;
	logic [7:0] line_byte;

	modport source (output valid, command, reg_addr, write_data, line_byte, input ready);
	modport sink (input valid, command, reg_addr, write_data, line_byte, output ready);
endinterface

interface u16rb_rsp_if import u16rb_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       irq_line;
	logic       tx_valid;
	logic [7:0] tx_byte;

	modport source (output valid, read_data, irq_line, tx_valid, tx_byte, input ready);
	modport sink (input valid, read_data, irq_line, tx_valid, tx_byte, output ready);
endinterface

@@ rtl/uart_16550_register_block.sv @@
// An accepted request is registered into the memory stage, then the response stage.
// Throughput: one request per cycle while the output is not stalled; each FIFO
// memory takes one write or one read. Pointers, counts and registers update at the
// accept edge, where the memory read is also registered; a response stage parts the
// output handshake. Reset clears pointers, counts and registers; the FIFO memories
// are not cleared and need no clearing pass, since only filled entries are ever read.
// ----------------------------------------------------------------------------
// UART 16550 register block
// Bus registers, receive and transmit FIFOs in RAM, and interrupt logic.
// ----------------------------------------------------------------------------
`include "uart_16550_register_block_defines.svh"

module uart_16550_register_block import u16rb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	u16rb_req_if.sink  req,
	u16rb_rsp_if.source rsp
);

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);
	localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);
	localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W+1)'(FIFO_DEPTH);

	// Architectural state.
	logic [PTR_W-1:0] rx_head_q, tx_head_q;
	logic [CNT_W-1:0] rx_count_q, tx_count_q;
	logic [3:0]       int_enable_q;
	logic [7:0]       line_control_q, divisor_low_q, divisor_high_q;
	logic             fifo_on_q, thre_pending_q;

	logic [PTR_W-1:0] rx_head_d, tx_head_d;
	logic [CNT_W-1:0] rx_count_d, tx_count_d;
	logic [3:0]       int_enable_d;
	logic [7:0]       line_control_d, divisor_low_d, divisor_high_d;
	logic             fifo_on_d, thre_pending_d;

	// Pipeline.
	s1_t              ctl_d, ctl_s1;
	logic             valid_s1;
	logic             out_valid_q;
	logic [7:0]       read_data_q, tx_byte_q;
	logic             irq_q, tx_valid_q;
	logic             advance, accept;

	// Memory ports.
	logic             rx_we, tx_we, rx_re, tx_re;
	logic [PTR_W-1:0] rx_waddr, tx_waddr;
	logic [7:0]       rx_rdata, tx_rdata;

	logic             dlab, rx_full, tx_full, fcr_on, fcr_clr_tx;
	logic [CNT_W:0]   rx_sum, tx_sum;
	logic [7:0]       iir_val;

	assign advance   = !out_valid_q || rsp.ready;
	assign req.ready = advance || !valid_s1;
	assign accept    = req.valid && req.ready;

	assign dlab    = line_control_q[LCR_DLAB_BIT];
	assign rx_full = fifo_on_q ? (rx_count_q == DEPTH_CNT) : (rx_count_q != '0);
	assign tx_full = fifo_on_q ? (tx_count_q == DEPTH_CNT) : (tx_count_q != '0);

	// Tail address is (head + count) modulo the depth.
	assign rx_sum   = (CNT_W+1)'(rx_head_q) + {1'b0, rx_count_q};
	assign tx_sum   = (CNT_W+1)'(tx_head_q) + {1'b0, tx_count_q};
	assign rx_waddr = (rx_sum >= DEPTH_SUM) ? PTR_W'(rx_sum - DEPTH_SUM) : PTR_W'(rx_sum);
	assign tx_waddr = (tx_sum >= DEPTH_SUM) ? PTR_W'(tx_sum - DEPTH_SUM) : PTR_W'(tx_sum);

	assign fcr_on     = req.write_data[FCR_EN_BIT];
	assign fcr_clr_tx = (fcr_on != fifo_on_q) || req.write_data[FCR_TX_CLR_BIT];

	always_comb begin
		rx_head_d      = rx_head_q;
		rx_count_d     = rx_count_q;
		tx_head_d      = tx_head_q;
		tx_count_d     = tx_count_q;
		int_enable_d   = int_enable_q;
		line_control_d = line_control_q;
		divisor_low_d  = divisor_low_q;
		divisor_high_d = divisor_high_q;
		fifo_on_d      = fifo_on_q;
		thre_pending_d = thre_pending_q;
		ctl_d          = '0;
		rx_we          = 1'b0;
		tx_we          = 1'b0;
		iir_val        = IIR_NONE;

		case (req.command)
			CMD_READ: begin
				case (req.reg_addr)
					REG_DATA: begin
						if (dlab) begin
							ctl_d.read_data = divisor_low_q;
						end else if (rx_count_q != '0) begin
							ctl_d.rx_pop = 1'b1;
							rx_head_d    = (rx_head_q == LAST_PTR) ? '0 : rx_head_q + 1'b1;
							rx_count_d   = rx_count_q - ONE_CNT;
						end
					end
					REG_IER: begin
						ctl_d.read_data = dlab ? divisor_high_q : {4'b0, int_enable_q};
					end
					REG_IIR: begin
						if (int_enable_q[IER_RDA_BIT] && rx_count_q != '0) begin
							iir_val = IIR_RDA;
						end else if (int_enable_q[IER_THRE_BIT] && thre_pending_q) begin
							// Reporting transmit-empty acknowledges it.
							iir_val        = IIR_THRE;
							thre_pending_d = 1'b0;
						end
						ctl_d.read_data = fifo_on_q ? (iir_val | IIR_FIFO_ON) : iir_val;
					end
					REG_LCR: begin
						ctl_d.read_data = line_control_q;
					end
					REG_LSR: begin
						ctl_d.read_data = ((rx_count_q != '0) ? LSR_DR : 8'h00)
							| ((tx_count_q == '0) ? LSR_TX_IDLE : 8'h00);
					end
					default: begin
					end
				endcase
			end
			CMD_WRITE: begin
				case (req.reg_addr)
					REG_DATA: begin
						if (dlab) begin
							divisor_low_d = req.write_data;
						end else begin
							if (!tx_full) begin
								tx_we      = 1'b1;
								tx_count_d = tx_count_q + ONE_CNT;
							end
							thre_pending_d = 1'b0;
						end
					end
					REG_IER: begin
						if (dlab) begin
							divisor_high_d = req.write_data;
						end else begin
							int_enable_d = req.write_data[3:0];
							if (req.write_data[IER_THRE_BIT] && tx_count_q == '0) begin
								thre_pending_d = 1'b1;
							end
						end
					end
					REG_IIR: begin
						// A change of the enable bit clears both FIFOs.
						if ((fcr_on != fifo_on_q) || req.write_data[FCR_RX_CLR_BIT]) begin
							rx_head_d  = '0;
							rx_count_d = '0;
						end
						if (fcr_clr_tx) begin
							if (tx_count_q != '0) begin
								thre_pending_d = 1'b1;
							end
							tx_head_d  = '0;
							tx_count_d = '0;
						end
						fifo_on_d = fcr_on;
					end
					REG_LCR: begin
						line_control_d = req.write_data;
					end
					default: begin
					end
				endcase
			end
			CMD_LINE_RX: begin
				if (!rx_full) begin
					rx_we      = 1'b1;
					rx_count_d = rx_count_q + ONE_CNT;
				end
			end
			default: begin
				if (tx_count_q != '0) begin
					ctl_d.tx_pop = 1'b1;
					tx_head_d    = (tx_head_q == LAST_PTR) ? '0 : tx_head_q + 1'b1;
					tx_count_d   = tx_count_q - ONE_CNT;
					if (tx_count_q == ONE_CNT) begin
						thre_pending_d = 1'b1;
					end
				end
			end
		endcase

		ctl_d.irq = (int_enable_d[IER_RDA_BIT] && rx_count_d != '0)
			|| (int_enable_d[IER_THRE_BIT] && thre_pending_d);
	end

	// Only one request touches a FIFO per cycle, so a read and a write of the
	// same memory never meet in one cycle and no forwarding is needed.
	assign rx_re = accept && ctl_d.rx_pop;
	assign tx_re = accept && ctl_d.tx_pop;

	u16rb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (accept && rx_we),
		.waddr (rx_waddr),
		.wdata (req.line_byte),
		.re    (rx_re),
		.raddr (rx_head_q),
		.rdata (rx_rdata)
	);

	u16rb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (accept && tx_we),
		.waddr (tx_waddr),
		.wdata (req.write_data),
		.re    (tx_re),
		.raddr (tx_head_q),
		.rdata (tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q      <= '0;
			rx_count_q     <= '0;
			tx_head_q      <= '0;
			tx_count_q     <= '0;
			int_enable_q   <= '0;
			line_control_q <= '0;
			divisor_low_q  <= '0;
			divisor_high_q <= '0;
			fifo_on_q      <= 1'b0;
			thre_pending_q <= 1'b0;
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				rx_head_q      <= rx_head_d;
				rx_count_q     <= rx_count_d;
				tx_head_q      <= tx_head_d;
				tx_count_q     <= tx_count_d;
				int_enable_q   <= int_enable_d;
				line_control_q <= line_control_d;
				divisor_low_q  <= divisor_low_d;
				divisor_high_q <= divisor_high_d;
				fifo_on_q      <= fifo_on_d;
				thre_pending_q <= thre_pending_d;
			end
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_d;
		end
		if (advance && valid_s1) begin
			read_data_q <= ctl_s1.rx_pop ? rx_rdata : ctl_s1.read_data;
			irq_q       <= ctl_s1.irq;
			tx_valid_q  <= ctl_s1.tx_pop;
			tx_byte_q   <= ctl_s1.tx_pop ? tx_rdata : 8'h00;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = read_data_q;
	assign rsp.irq_line  = irq_q;
	assign rsp.tx_valid  = tx_valid_q;
	assign rsp.tx_byte   = tx_byte_q;

	`U16RB_ASSERT(a_rx_count_range, rx_count_q <= DEPTH_CNT, "receive count beyond depth")
	`U16RB_ASSERT(a_holding_reg, fifo_on_q || (rx_count_q <= ONE_CNT && tx_count_q <= ONE_CNT),
		"more than one byte held with FIFOs disabled")
	`U16RB_ASSERT(a_stall_blocks, !(valid_s1 && !advance && req.ready),
		"request taken while the memory stage is stalled")
	`U16RB_ASSERT_NEXT(a_tx_pop_count, accept && ctl_d.tx_pop,
		tx_count_q == $past(tx_count_q) - ONE_CNT, "transmit pop did not lower the count")
	`U16RB_ASSERT_NEXT(a_tx_drain_thre, accept && ctl_d.tx_pop && tx_count_q == ONE_CNT,
		thre_pending_q, "transmit FIFO drained without transmit-empty pending")

endmodule

@@ rtl/u16rb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
module u16rb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
